FILE: hdl/cfd_pkg.sv
// Shared types, constants and CRC function for the sensor frame decoder.
package cfd_pkg;

    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [7:0]  CRC_POLY = 8'h31;

    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_W0_HI  = 4'd0;
    localparam logic [POS_W-1:0] POS_W0_LO  = 4'd1;
    localparam logic [POS_W-1:0] POS_W0_CRC = 4'd2;
    localparam logic [POS_W-1:0] POS_W1_HI  = 4'd3;
    localparam logic [POS_W-1:0] POS_W1_LO  = 4'd4;
    localparam logic [POS_W-1:0] POS_W1_CRC = 4'd5;
    localparam logic [POS_W-1:0] POS_W2_HI  = 4'd6;
    localparam logic [POS_W-1:0] POS_W2_LO  = 4'd7;
    localparam logic [POS_W-1:0] POS_W2_CRC = 4'd8;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    localparam int unsigned TEMP_PROD_W = 31;
    localparam int unsigned HUM_PROD_W  = 30;

    typedef struct packed {
        logic        error;
        logic [15:0] co2_word;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } frame_t;

    typedef struct packed {
        logic                   error;
        logic [15:0]            co2_word;
        logic [TEMP_PROD_W-1:0] temp_prod;
        logic [HUM_PROD_W-1:0]  hum_prod;
    } product_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/cfd_frame_assembler.sv
// Byte position tracking, word assembly and per-word CRC check.
module cfd_frame_assembler
    import cfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_take,
    input  logic [7:0] frame_byte,
    input  logic       frame_start,
    input  logic       down_free,
    output logic       frm_free,
    output logic       frm_valid,
    output frame_t     frm
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic             err_reg, err_next;
    logic [7:0]       hi_reg, hi_next;
    logic [15:0]      w0_reg, w0_next;
    logic [15:0]      w1_reg, w1_next;
    logic [15:0]      w2_reg, w2_next;
    logic             frm_valid_reg, frm_valid_next;
    frame_t           frm_reg, frm_next;

    logic [POS_W-1:0] pos_eff;
    logic             err_base;
    logic             crc_bad;
    logic             frm_load;

    assign frm_free  = !frm_valid_reg || down_free;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    always_comb
    begin
        pos_eff  = frame_start ? POS_W0_HI : pos_reg;
        err_base = (pos_eff == POS_W0_HI) ? 1'b0 : err_reg;
        crc_bad  = (crc_reg != frame_byte);
        pos_next = pos_reg;
        crc_next = crc_reg;
        err_next = err_reg;
        hi_next  = hi_reg;
        w0_next  = w0_reg;
        w1_next  = w1_reg;
        w2_next  = w2_reg;
        frm_load = 1'b0;
        frm_next = frm_reg;
        if (byte_take)
        begin
            if (frame_start)
            begin
                pos_next = POS_W0_HI;
                crc_next = CRC_INIT;
                err_next = 1'b0;
            end
            unique case (pos_eff)
                POS_W0_HI, POS_W1_HI, POS_W2_HI:
                begin
                    crc_next = crc8_byte(CRC_INIT, frame_byte);
                    hi_next  = frame_byte;
                    err_next = err_base;
                    pos_next = pos_eff + 1'b1;
                end
                POS_W0_LO, POS_W1_LO, POS_W2_LO:
                begin
                    crc_next = crc8_byte(crc_reg, frame_byte);
                    err_next = err_base;
                    pos_next = pos_eff + 1'b1;
                    if (pos_eff == POS_W0_LO)
                        w0_next = {hi_reg, frame_byte};
                    else if (pos_eff == POS_W1_LO)
                        w1_next = {hi_reg, frame_byte};
                    else
                        w2_next = {hi_reg, frame_byte};
                end
                POS_W0_CRC, POS_W1_CRC, POS_W2_CRC:
                begin
                    crc_next = CRC_INIT;
                    err_next = err_base | crc_bad;
                    pos_next = pos_eff + 1'b1;
                    if (pos_eff == POS_W2_CRC)
                    begin
                        frm_load           = 1'b1;
                        frm_next.error     = err_base | crc_bad;
                        frm_next.co2_word  = w0_reg;
                        frm_next.temp_word = w1_reg;
                        frm_next.hum_word  = w2_reg;
                    end
                end
                default:
                begin
                    // frame complete: ignore bytes until the next start
                end
            endcase
        end
        if (frm_free)
            frm_valid_next = frm_load;
        else
            frm_valid_next = frm_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_W0_HI;
            crc_reg       <= CRC_INIT;
            err_reg       <= 1'b0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            err_reg       <= err_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        w2_reg  <= w2_next;
        frm_reg <= frm_next;
    end

endmodule

FILE: hdl/cfd_converter.sv
// Fixed-point conversion of a checked frame and last-good result register.
module cfd_converter
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frm_valid,
    input  frame_t             frm,
    output logic               down_free,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               status,
    output logic [15:0]        co2_ppm,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi
);

    logic        mul_valid_reg, mul_valid_next;
    product_t    mul_reg, mul_next;
    logic        res_valid_reg, res_valid_next;
    logic        status_reg, status_next;
    logic [15:0] co2_reg, co2_next;
    logic [14:0] temp_reg, temp_next;
    logic [13:0] hum_reg, hum_next;
    logic        out_free;

    assign out_free  = !res_valid_reg || !result_stall;
    assign down_free = !mul_valid_reg || out_free;

    assign result_valid      = res_valid_reg;
    assign status            = status_reg;
    assign co2_ppm           = co2_reg;
    assign temperature_centi = signed'(temp_reg);
    assign humidity_centi    = hum_reg;

    always_comb
    begin
        mul_next           = mul_reg;
        mul_valid_next     = mul_valid_reg;
        if (down_free)
        begin
            mul_valid_next     = frm_valid;
            mul_next.error     = frm.error;
            mul_next.co2_word  = frm.co2_word;
            mul_next.temp_prod = TEMP_PROD_W'(frm.temp_word) * TEMP_PROD_W'(TEMP_SCALE);
            mul_next.hum_prod  = HUM_PROD_W'(frm.hum_word) * HUM_PROD_W'(HUM_SCALE);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        status_next    = status_reg;
        co2_next       = co2_reg;
        temp_next      = temp_reg;
        hum_next       = hum_reg;
        if (out_free)
        begin
            res_valid_next = mul_valid_reg;
            if (mul_valid_reg)
            begin
                status_next = mul_reg.error;
                if (!mul_reg.error)
                begin
                    co2_next  = mul_reg.co2_word;
                    temp_next = mul_reg.temp_prod[TEMP_PROD_W-1:16] - TEMP_OFFSET;
                    hum_next  = mul_reg.hum_prod[HUM_PROD_W-1:16];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            co2_reg       <= '0;
            temp_reg      <= '0;
            hum_reg       <= '0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            res_valid_reg <= res_valid_next;
            co2_reg       <= co2_next;
            temp_reg      <= temp_next;
            hum_reg       <= hum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg    <= mul_next;
        status_reg <= status_next;
    end

endmodule

FILE: hdl/co2_sensor_frame_decoder_core.sv
// Sensor frame decoder: 9-byte frame in, one checked and converted measurement out.
//
// Input channel: frame_byte/frame_start with frame_valid/frame_stall. One byte is
// transferred per cycle while frame_stall is low; frame_start marks byte 0 and drops
// any partial frame. Bytes after the ninth are ignored until the next frame_start.
// Output channel: status, co2_ppm, temperature_centi, humidity_centi with
// result_valid/result_stall. One result per complete frame; status 1 means a word
// CRC failed and the last good values are repeated.
// After the ninth byte is transferred, the result passes through the frame register,
// the multiplier register and the result register, which drives result_valid.
// Throughput: one byte per cycle while frame_stall is low; the CRC update is
// combinational XOR logic.
// When result_stall is held, the pipeline fills and frame_stall rises once the
// frame register is occupied; no transfer is lost.
// Reset: position 0, CRC 0xFF, last good values zero, all stages empty.
module co2_sensor_frame_decoder_core
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  logic [7:0]         frame_byte,
    input  logic               frame_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               status,
    output logic [15:0]        co2_ppm,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi
);

    logic   frm_free;
    logic   frm_valid;
    logic   down_free;
    logic   byte_take;
    frame_t frm;

    assign frame_stall = !frm_free;
    assign byte_take   = frame_valid && frm_free;

    cfd_frame_assembler u_assembler (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .down_free   (down_free),
        .frm_free    (frm_free),
        .frm_valid   (frm_valid),
        .frm         (frm)
    );

    cfd_converter u_converter (
        .clk               (clk),
        .rst_n             (rst_n),
        .frm_valid         (frm_valid),
        .frm               (frm),
        .down_free         (down_free),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .co2_ppm           (co2_ppm),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

endmodule

FILE: sim/co2_frame_checker.sv
// Checker for the sensor frame decoder: predicts readings from byte transfers and compares results.
module co2_frame_checker
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    input  logic               frame_stall,
    input  logic [7:0]         frame_byte,
    input  logic               frame_start,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic               status,
    input  logic [15:0]        co2_ppm,
    input  logic signed [14:0] temperature_centi,
    input  logic [13:0]        humidity_centi,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               crc_fail;
        logic [15:0]        co2;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } reading_t;

    reading_t expected_readings[$];

    logic [3:0]         frame_pos;
    logic [7:0]         group_crc;
    logic [7:0]         high_byte;
    logic [15:0]        words [3];
    logic               crc_failed;
    logic [15:0]        good_co2;
    logic signed [14:0] good_temp;
    logic [13:0]        good_hum;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ b[i])
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic s);
        logic [3:0]  cur;
        logic [1:0]  off;
        logic [1:0]  grp;
        logic [31:0] t_full;
        logic [31:0] h_full;
        if (s)
        begin
            frame_pos  = POS_W0_HI;
            group_crc  = CRC_INIT;
            crc_failed = 1'b0;
        end
        cur = frame_pos;
        if (cur > POS_W2_CRC)
            return;
        if (cur == POS_W0_HI && !s)
        begin
            group_crc  = CRC_INIT;
            crc_failed = 1'b0;
        end
        off = 2'(cur % 3);
        grp = 2'(cur / 3);
        case (off)
            2'd0:
            begin
                group_crc = crc_step(CRC_INIT, b);
                high_byte = b;
            end
            2'd1:
            begin
                group_crc  = crc_step(group_crc, b);
                words[grp] = {high_byte, b};
            end
            default:
            begin
                if (group_crc != b)
                    crc_failed = 1'b1;
                group_crc = CRC_INIT;
            end
        endcase
        frame_pos = cur + 4'd1;
        if (cur != POS_W2_CRC)
            return;
        if (!crc_failed)
        begin
            t_full    = (32'd17500 * words[1]) >> 16;
            h_full    = (32'd10000 * words[2]) >> 16;
            good_co2  = words[0];
            good_temp = 15'(t_full - 32'd4500);
            good_hum  = 14'(h_full);
        end
        expected_readings.push_back('{crc_failed, good_co2, good_temp, good_hum});
    endtask

    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            frame_pos  = POS_W0_HI;
            group_crc  = CRC_INIT;
            high_byte  = '0;
            words      = '{default: '0};
            crc_failed = 1'b0;
            good_co2   = '0;
            good_temp  = '0;
            good_hum   = '0;
            expected_readings.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
                decode_byte(frame_byte, frame_start);
            if (result_valid && !result_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, got status=%0b co2=%0d",
                             $time, status, co2_ppm);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("status", {16'd0, want.crc_fail}, {16'd0, status});
                    check_field("co2_ppm", {1'b0, want.co2}, {1'b0, co2_ppm});
                    check_field("temperature_centi", {{2{want.temp[14]}}, want.temp},
                                {{2{temperature_centi[14]}}, temperature_centi});
                    check_field("humidity_centi", {3'd0, want.hum}, {3'd0, humidity_centi});
                end
            end
            pending = expected_readings.size();
        end
    end

endmodule

FILE: sim/tb_co2_sensor_frame_decoder_core.sv
// Testbench top for the sensor frame decoder: drives byte frames, result stalls and the verdict.
module tb_co2_sensor_frame_decoder_core
    import cfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 630;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               frame_valid;
    logic               frame_stall;
    logic [7:0]         frame_byte;
    logic               frame_start;
    logic               result_valid;
    logic               result_stall;
    logic               status;
    logic [15:0]        co2_ppm;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    int errors;
    int pending;
    int send_pct    = 0;
    int recv_pct    = 0;
    int hold_reqs   = 0;
    int holds_done  = 0;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    co2_sensor_frame_decoder_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_valid       (frame_valid),
        .frame_stall       (frame_stall),
        .frame_byte        (frame_byte),
        .frame_start       (frame_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .co2_ppm           (co2_ppm),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

    co2_frame_checker chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_valid       (frame_valid),
        .frame_stall       (frame_stall),
        .frame_byte        (frame_byte),
        .frame_start       (frame_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .co2_ppm           (co2_ppm),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .errors            (errors),
        .pending           (pending)
    );

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold on request
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_reqs)
            begin
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
                holds_done++;
            end
            result_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < send_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte  <= b;
        frame_start <= s;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    task automatic put_frame(input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic s, input logic [2:0] bad);
        logic [15:0] w [3];
        logic [7:0]  c;
        w = '{w0, w1, w2};
        for (int g = 0; g < 3; g++)
        begin
            c = crc8_byte(crc8_byte(CRC_INIT, w[g][15:8]), w[g][7:0]);
            if (bad[g])
                c ^= 8'($urandom_range(1, 255));
            put_byte(w[g][15:8], s && g == 0);
            put_byte(w[g][7:0], 1'b0);
            put_byte(c, 1'b0);
        end
    endtask

    task automatic drain();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int target);
        int done;
        int kind;
        int len;
        done = 0;
        while (done < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                put_frame(rand_word(), rand_word(), rand_word(), $urandom_range(0, 19) != 0,
                          {$urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                           $urandom_range(0, 11) == 0});
                done += 9;
            end
            else if (kind < 90)
            begin
                // truncated frame, dropped by the next start
                len = $urandom_range(1, 8);
                put_byte(8'($urandom), 1'b1);
                for (int i = 1; i < len; i++)
                    put_byte(8'($urandom), 1'b0);
                done += len;
            end
            else
            begin
                put_byte(8'($urandom), $urandom_range(0, 4) == 0);
                done += 1;
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame_byte  <= '0;
        frame_start <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame after reset needs no start flag
        put_frame(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 3'b000);
        // ignored after a complete frame
        put_byte(8'hA5, 1'b0);
        // partial frame, then restart
        put_byte(8'h12, 1'b1);
        put_byte(8'h34, 1'b0);
        put_frame(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 3'b000);
        drain();

        send_pct = 7;
        recv_pct = 52;
        run_phase(PHASE_BYTES);
        drain();

        send_pct = 52;
        recv_pct = 7;
        run_phase(PHASE_BYTES);
        drain();

        send_pct = 0;
        recv_pct = 0;
        hold_reqs++;
        run_phase(PHASE_BYTES);
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
